FILE: rtl/mvpid_pkg.sv
// shared types, register codes and constants for the motor velocity pid block
// no dependencies; imported by mvpid_drive and motor_velocity_pid_can_current
package mvpid_pkg;

  // field widths
  localparam int RpmW    = 16;
  localparam int ErrW    = 17;
  localparam int DiffW   = 18;
  localparam int GainW   = 24;
  localparam int LimW    = 15;
  localparam int IdW     = 10;
  localparam int TimeW   = 32;
  localparam int PeriodW = 16;
  localparam int ClampW  = 28;
  localparam int FracW   = 16;

  // can frame ids and motor split
  localparam logic [IdW-1:0] FRAME_LOW_MOTORS  = 10'h200;
  localparam logic [IdW-1:0] FRAME_HIGH_MOTORS = 10'h1FF;
  localparam logic [IdW-1:0] LAST_LOW_MOTOR    = 10'h204;

  // register reset values
  localparam logic [GainW-1:0]   KP_RESET     = 24'd65536;
  localparam logic [GainW-1:0]   KI_RESET     = 24'd6554;
  localparam logic [GainW-1:0]   KD_RESET     = 24'd0;
  localparam logic [PeriodW-1:0] PERIOD_RESET = 16'd10;
  localparam logic [LimW-1:0]    LIMIT_RESET  = 15'd10000;
  localparam logic [IdW-1:0]     MOTOR_RESET  = 10'h201;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_KP       = 3'd0,
    REG_KI       = 3'd1,
    REG_KD       = 3'd2,
    REG_PERIOD   = 3'd3,
    REG_LIMIT    = 3'd4,
    REG_MOTOR_ID = 3'd5
  } cfg_reg_t;

  // error terms handed from the state update stage to the drive datapath
  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [ErrW-1:0]  integ;
    logic signed [DiffW-1:0] diff;
    logic                    recomp;
  } mvpid_terms_t;

  // stage load strobes for the drive datapath
  typedef struct packed {
    logic load_prod;
    logic load_out;
    logic take_out;
  } mvpid_ctl_t;

  // symmetric clamp to +/- lim
  function automatic logic signed [ClampW-1:0] clamp_sym(
    input logic signed [ClampW-1:0] x,
    input logic [LimW-1:0]          lim
  );
    logic signed [ClampW-1:0] hi;
    hi = signed'({{(ClampW-LimW){1'b0}}, lim});
    if (x > hi) begin
      return hi;
    end else if (x < -hi) begin
      return -hi;
    end
    return x;
  endfunction

endpackage

FILE: rtl/mvpid_drive.sv
// drive datapath: registered gain products, then sum, truncate and clamp
// depends on mvpid_pkg
module mvpid_drive (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mvpid_pkg::mvpid_ctl_t                ctl,
  input  mvpid_pkg::mvpid_terms_t              terms,
  input  logic signed [mvpid_pkg::GainW-1:0]   kp,
  input  logic signed [mvpid_pkg::GainW-1:0]   ki,
  input  logic signed [mvpid_pkg::GainW-1:0]   kd,
  input  logic [mvpid_pkg::LimW-1:0]           lim,
  output logic signed [mvpid_pkg::RpmW-1:0]    drive_current,
  output logic                                 recomputed
);
  import mvpid_pkg::*;

  localparam int PW  = GainW + ErrW;
  localparam int DW  = GainW + DiffW;
  localparam int SW  = DW + 2;

  logic signed [PW-1:0] prod_p;
  logic signed [PW-1:0] prod_i;
  logic signed [DW-1:0] prod_d;
  logic                 recomp_p;

  logic signed [SW-1:0]     acc;
  logic signed [SW-FracW:0] quot;
  logic signed [ClampW-1:0] clamped;
  logic signed [RpmW-1:0]   drive_next;

  // product stage
  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod_p   <= kp * terms.err;
      prod_i   <= ki * terms.integ;
      prod_d   <= kd * terms.diff;
      recomp_p <= terms.recomp;
    end
  end

  // sum, truncate toward zero, clamp
  always_comb begin
    acc = SW'(prod_p) + SW'(prod_i) + SW'(prod_d);
    quot = (SW-FracW+1)'(acc >>> FracW);
    if (acc[SW-1] && (acc[FracW-1:0] != '0)) begin
      quot = quot + (SW-FracW+1)'(1);
    end
    clamped = clamp_sym(ClampW'(quot), lim);
    drive_next = recomp_p ? clamped[RpmW-1:0] : drive_current;
  end

  // output register doubles as the held drive
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_current <= '0;
    end else if (ctl.take_out) begin
      drive_current <= drive_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      recomputed <= recomp_p;
    end
  end

endmodule

FILE: rtl/motor_velocity_pid_can_current.sv
// top level of the motor velocity pid block with can current slot output
// depends on mvpid_pkg and mvpid_drive
//
//  channel   | dir | handshake           | payload
//  s_*       | in  | s_tvalid / s_tready | setpoint, measured, timestamp
//  m_*       | out | m_tvalid / m_tready | drive current, frame id, slot; tuser flag
//  cfg_*     | in  | cfg_valid/cfg_ready | register index and write data
//
// one transaction per cycle sustained while m_tready is high; each transaction passes
// the input register, state update, products and result registers in order.
// the state update stage updates integral and timestamp in the cycle its terms load.
// reset is synchronous and clears state, config registers, drive and all valid flags.
// a stalled output holds its result while bubbles behind it keep filling.
module motor_velocity_pid_can_current (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // setpoint_rpm[15:0], measured_rpm[31:16], now_ms[63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // drive_current[15:0], frame_id[25:16], byte_slot[27:26]
  output logic [0:0]  m_tuser,   // recomputed[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_data
);
  import mvpid_pkg::*;

  // configuration registers
  logic signed [GainW-1:0] kp;
  logic signed [GainW-1:0] ki;
  logic signed [GainW-1:0] kd;
  logic [PeriodW-1:0]      period;
  logic [LimW-1:0]         lim;
  logic [IdW-1:0]          motor_id;

  // pipeline valid flags and free signals
  logic v0, v1, v2, vout;
  logic free0, free1, free2, free_out;

  // input register
  logic signed [RpmW-1:0] sp0;
  logic signed [RpmW-1:0] meas0;
  logic [TimeW-1:0]       now0;

  // controller state
  logic signed [ErrW-1:0] error_integral;
  logic signed [ErrW-1:0] previous_error;
  logic [TimeW-1:0]       last_update_ms;

  // state update stage signals
  logic [TimeW-1:0]         elapsed;
  logic                     recomp;
  logic signed [ErrW-1:0]   err;
  logic signed [ClampW-1:0] isum;
  logic signed [ClampW-1:0] iclamp;
  mvpid_terms_t             terms_next;
  mvpid_terms_t             terms;
  mvpid_ctl_t               ctl;

  logic signed [RpmW-1:0] drive_current;
  logic                   recomputed;
  logic [IdW-1:0]         frame_id;
  logic [1:0]             byte_slot;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp       <= KP_RESET;
      ki       <= KI_RESET;
      kd       <= KD_RESET;
      period   <= PERIOD_RESET;
      lim      <= LIMIT_RESET;
      motor_id <= MOTOR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_KP:       kp       <= cfg_data;
        REG_KI:       ki       <= cfg_data;
        REG_KD:       kd       <= cfg_data;
        REG_PERIOD:   period   <= cfg_data[PeriodW-1:0];
        REG_LIMIT:    lim      <= cfg_data[LimW-1:0];
        REG_MOTOR_ID: motor_id <= cfg_data[IdW-1:0];
        default: ;
      endcase
    end
  end

  // flow control: a stage loads when it is empty or its content moves on
  assign free_out = !vout || m_tready;
  assign free2    = !v2 || free_out;
  assign free1    = !v1 || free2;
  assign free0    = !v0 || free1;
  assign s_tready = free0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      vout <= 1'b0;
    end else begin
      if (free0)    v0   <= s_tvalid;
      if (free1)    v1   <= v0;
      if (free2)    v2   <= v1;
      if (free_out) vout <= v2;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (free0) begin
      sp0   <= s_tdata[15:0];
      meas0 <= s_tdata[31:16];
      now0  <= s_tdata[63:32];
    end
  end

  // period check, error, integral with anti-windup clamp, difference
  always_comb begin
    elapsed = now0 - last_update_ms;
    recomp  = elapsed >= TimeW'(period);
    err     = ErrW'(sp0) - ErrW'(meas0);
    isum    = ClampW'(error_integral) + ClampW'(err);
    iclamp  = clamp_sym(isum, lim);
    terms_next.err    = err;
    terms_next.integ  = iclamp[ErrW-1:0];
    terms_next.diff   = DiffW'(err) - DiffW'(previous_error);
    terms_next.recomp = recomp;
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      terms <= terms_next;
    end
  end

  // controller state moves with each recomputing transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      error_integral <= '0;
      previous_error <= '0;
      last_update_ms <= '0;
    end else if (free1 && v0 && recomp) begin
      error_integral <= terms_next.integ;
      previous_error <= err;
      last_update_ms <= now0;
    end
  end

  // products and result stages
  assign ctl.load_prod = free2;
  assign ctl.load_out  = free_out;
  assign ctl.take_out  = free_out && v2;

  mvpid_drive u_drive (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .terms         (terms),
    .kp            (kp),
    .ki            (ki),
    .kd            (kd),
    .lim           (lim),
    .drive_current (drive_current),
    .recomputed    (recomputed)
  );

  // frame and slot follow the motor id
  assign frame_id  = (motor_id <= LAST_LOW_MOTOR) ? FRAME_LOW_MOTORS : FRAME_HIGH_MOTORS;
  assign byte_slot = motor_id[1:0] - 2'd1;

  assign m_tvalid = vout;
  assign m_tdata  = {4'd0, byte_slot, frame_id, drive_current};
  assign m_tuser  = recomputed;

endmodule

FILE: rtl/mvpid_checker.sv
// port-level checks for the motor velocity pid block
// no package dependency; bound to motor_velocity_pid_can_current below
module mvpid_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds its transaction
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // frame id is one of the two command frames
  a_frame_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[25:16] == 10'h200) || (m_tdata[25:16] == 10'h1FF))
    else $error("illegal frame id");

  // symmetric clamp never yields the most negative code
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:0] != 16'h8000)
    else $error("drive outside clamp range");

endmodule

bind motor_velocity_pid_can_current mvpid_checker u_mvpid_checker (.*);
